// ===== rtl/ulli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulli_pkg
// shared constants, codes and types of the uniform grid interpolation unit
// ----------------------------------------------------------------------------
package ulli_pkg;

  // table geometry and arithmetic
  localparam int GRID_POINTS    = 16384;
  localparam int PROPERTY_COUNT = 3;
  localparam int WEIGHT_BITS    = 16;

  localparam int IDX_W  = $clog2(GRID_POINTS);
  localparam int CNT_W  = $clog2(GRID_POINTS + 1);
  localparam int DEPTH  = PROPERTY_COUNT * GRID_POINTS;
  localparam int ADDR_W = $clog2(DEPTH);

  // field widths
  localparam int PRESS_W = 48;
  localparam int STEP_W  = 32;
  localparam int PCNT_W  = 15;
  localparam int EIDX_W  = 14;
  localparam int VAL_W   = 32;
  localparam int SEL_W   = 2;
  localparam int STAT_W  = 2;

  // stream packing
  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  // config port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;
  localparam int REG_W  = CFG_AW - 3;

  localparam logic [REG_W-1:0] REG_PRESSURE_MIN = 2'd0;
  localparam logic [REG_W-1:0] REG_STEP_INVERSE = 2'd1;
  localparam logic [REG_W-1:0] REG_POINT_COUNT  = 2'd2;

  // item kinds
  localparam logic ACT_QUERY = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // clip status codes
  localparam logic [STAT_W-1:0] CLIP_NONE  = 2'd0;
  localparam logic [STAT_W-1:0] CLIP_BELOW = 2'd1;
  localparam logic [STAT_W-1:0] CLIP_ABOVE = 2'd2;

  // queue sizes
  localparam int QDEPTH   = 8;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OPTR_W   = $clog2(OUT_DEPTH);
  localparam int OCNT_W   = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic signed [PRESS_W-1:0] pressure_min;
    logic [STEP_W-1:0]         step_inverse;
    logic [PCNT_W-1:0]         point_count;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    logic                   is_write;
    logic                   sel_ok;
    logic                   interp;
    logic [SEL_W-1:0]       sel;
    logic [IDX_W-1:0]       idx;
    logic [STAT_W-1:0]      status;
    logic [WEIGHT_BITS-1:0] weight;
    logic [VAL_W-1:0]       wdata;
  } qent_t;

endpackage

// ===== rtl/ulli_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulli_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module ulli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/ulli_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulli_front
// accepts items, computes grid position and classifies each query
// ----------------------------------------------------------------------------
module ulli_front
  import ulli_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_action,
  input  logic [SEL_W-1:0]       in_sel,
  input  logic [PRESS_W-1:0]     in_pressure,
  input  logic [EIDX_W-1:0]      in_eidx,
  input  logic [VAL_W-1:0]       in_evalue,
  input  logic [QCNT_W-1:0]      q_count,
  output logic                   q_push,
  output qent_t                  q_data
);

  // stage 1: difference to grid start
  logic                 f1_v_r;
  logic                 f1_act_r;
  logic [SEL_W-1:0]     f1_sel_r;
  logic [EIDX_W-1:0]    f1_eidx_r;
  logic [VAL_W-1:0]     f1_eval_r;
  logic [PRESS_W:0]     f1_diff_r;
  logic [PRESS_W:0]     diff_nxt;

  // stage 2: partial products
  logic                 f2_v_r;
  logic                 f2_act_r;
  logic [SEL_W-1:0]     f2_sel_r;
  logic [EIDX_W-1:0]    f2_eidx_r;
  logic [VAL_W-1:0]     f2_eval_r;
  logic                 f2_neg_r;
  logic [63:0]          f2_hi_r;
  logic [47:0]          f2_lo_r;
  logic [63:0]          hi_nxt;
  logic [47:0]          lo_nxt;

  // stage 3: position, 32 fraction bits
  logic                 f3_v_r;
  logic                 f3_act_r;
  logic [SEL_W-1:0]     f3_sel_r;
  logic [EIDX_W-1:0]    f3_eidx_r;
  logic [VAL_W-1:0]     f3_eval_r;
  logic                 f3_neg_r;
  logic [79:0]          f3_pos_r;
  logic [79:0]          pos_nxt;

  logic                 accept;
  logic [QCNT_W:0]      credit;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     last;
  logic [47:0]          pos_idx;
  logic [31:0]          pos_frac;
  logic                 at_last;
  logic                 beyond;
  logic                 sel_ok;

  // room in the queue for everything already in flight
  assign credit   = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(f1_v_r)
                  + (QCNT_W + 1)'(f2_v_r) + (QCNT_W + 1)'(f3_v_r);
  assign in_ready = credit < (QCNT_W + 1)'(QDEPTH);
  assign accept   = in_valid & in_ready;

  assign diff_nxt = {in_pressure[PRESS_W-1], in_pressure}
                  - {cfg.pressure_min[PRESS_W-1], cfg.pressure_min};
  assign hi_nxt   = f1_diff_r[47:16] * cfg.step_inverse;
  assign lo_nxt   = f1_diff_r[15:0] * cfg.step_inverse;
  assign pos_nxt  = {f2_hi_r, 16'd0} + {32'd0, f2_lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else begin
      f1_v_r <= accept;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_act_r  <= in_action;
    f1_sel_r  <= in_sel;
    f1_eidx_r <= in_eidx;
    f1_eval_r <= in_evalue;
    f1_diff_r <= diff_nxt;

    f2_act_r  <= f1_act_r;
    f2_sel_r  <= f1_sel_r;
    f2_eidx_r <= f1_eidx_r;
    f2_eval_r <= f1_eval_r;
    f2_neg_r  <= f1_diff_r[PRESS_W];
    f2_hi_r   <= hi_nxt;
    f2_lo_r   <= lo_nxt;

    f3_act_r  <= f2_act_r;
    f3_sel_r  <= f2_sel_r;
    f3_eidx_r <= f2_eidx_r;
    f3_eval_r <= f2_eval_r;
    f3_neg_r  <= f2_neg_r;
    f3_pos_r  <= pos_nxt;
  end

  // point count clamped to the range 2 to the table size
  always_comb begin
    if (cfg.point_count < PCNT_W'(2)) begin
      cnt = CNT_W'(2);
    end else if (32'(cfg.point_count) > GRID_POINTS) begin
      cnt = CNT_W'(GRID_POINTS);
    end else begin
      cnt = CNT_W'(cfg.point_count);
    end
  end

  assign last     = cnt - CNT_W'(1);
  assign pos_idx  = f3_pos_r[79:32];
  assign pos_frac = f3_pos_r[31:0];
  assign at_last  = pos_idx == 48'(last);
  assign beyond   = (pos_idx > 48'(last)) || (at_last && (pos_frac != 32'd0));
  assign sel_ok   = 32'(f3_sel_r) < PROPERTY_COUNT;

  always_comb begin
    q_push          = f3_v_r;
    q_data.is_write = f3_act_r == ACT_WRITE;
    q_data.sel      = f3_sel_r;
    q_data.wdata    = f3_eval_r;
    q_data.interp   = 1'b0;
    q_data.weight   = '0;
    q_data.status   = CLIP_NONE;
    q_data.idx      = '0;
    if (f3_act_r == ACT_WRITE) begin
      q_data.sel_ok = sel_ok && (32'(f3_eidx_r) < GRID_POINTS);
      q_data.idx    = IDX_W'(f3_eidx_r);
    end else begin
      q_data.sel_ok = sel_ok;
      if (f3_neg_r) begin
        q_data.status = CLIP_BELOW;
      end else if (beyond) begin
        q_data.status = CLIP_ABOVE;
        q_data.idx    = IDX_W'(last);
      end else if (at_last) begin
        q_data.idx    = IDX_W'(last);
      end else begin
        q_data.interp = 1'b1;
        q_data.idx    = IDX_W'(pos_idx);
        q_data.weight = pos_frac[31 -: WEIGHT_BITS];
      end
    end
  end

endmodule

// ===== rtl/ulli_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulli_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module ulli_queue
  import ulli_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qent_t             push_data,
  input  logic              pop,
  output qent_t             head,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  qent_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r;
  logic [QPTR_W-1:0]  rptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign head  = mem_r[rptr_r];
  assign empty = count_r == '0;
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/ulli_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulli_back
// table access, interpolation and result buffer
// ----------------------------------------------------------------------------
module ulli_back
  import ulli_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  qent_t             head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VAL_W-1:0]  out_value,
  output logic [STAT_W-1:0] out_status
);

  localparam int PROD_W = VAL_W + 1 + WEIGHT_BITS + 1;
  localparam logic signed [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (WEIGHT_BITS - 1);

  logic              we;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [VAL_W-1:0]  rdata_a;
  logic [VAL_W-1:0]  rdata_b;
  logic [IDX_W-1:0]  idx_b;

  // stage 1: read data arriving
  logic                   b1_v_r;
  logic                   b1_ok_r;
  logic [STAT_W-1:0]      b1_stat_r;
  logic [WEIGHT_BITS-1:0] b1_w_r;

  // stage 2: slope
  logic                   b2_v_r;
  logic                   b2_ok_r;
  logic [STAT_W-1:0]      b2_stat_r;
  logic [WEIGHT_BITS-1:0] b2_w_r;
  logic [VAL_W-1:0]       b2_low_r;
  logic signed [VAL_W:0]  b2_d_r;
  logic signed [VAL_W:0]  d_nxt;

  // stage 3: weighted slope
  logic                     b3_v_r;
  logic                     b3_ok_r;
  logic [STAT_W-1:0]        b3_stat_r;
  logic [VAL_W-1:0]         b3_low_r;
  logic signed [PROD_W-1:0] b3_prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [WEIGHT_BITS:0] wext;

  logic signed [PROD_W:0] rnd;
  logic signed [PROD_W:0] step;
  logic [VAL_W-1:0]       val;

  // result buffer
  logic [VAL_W-1:0]  ob_val_r  [OUT_DEPTH];
  logic [STAT_W-1:0] ob_stat_r [OUT_DEPTH];
  logic [OPTR_W-1:0] ob_wptr_r;
  logic [OPTR_W-1:0] ob_rptr_r;
  logic [OCNT_W-1:0] ob_count_r;
  logic [OCNT_W:0]   credit;
  logic              ob_push;
  logic              ob_pop;

  assign credit = (OCNT_W + 1)'(ob_count_r) + (OCNT_W + 1)'(b1_v_r)
                + (OCNT_W + 1)'(b2_v_r) + (OCNT_W + 1)'(b3_v_r);
  assign pop    = !empty && (credit < (OCNT_W + 1)'(OUT_DEPTH));

  // table address, unknown tables read entry zero and are masked later
  assign base    = head.sel_ok ? ADDR_W'(32'(head.sel) * GRID_POINTS) : '0;
  assign idx_b   = head.interp ? head.idx + IDX_W'(1) : head.idx;
  assign waddr   = base + ADDR_W'(head.idx);
  assign raddr_a = head.sel_ok ? base + ADDR_W'(head.idx) : '0;
  assign raddr_b = head.sel_ok ? base + ADDR_W'(idx_b) : '0;
  assign we      = pop && head.is_write && head.sel_ok;

  ulli_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (head.wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign d_nxt    = {rdata_b[VAL_W-1], rdata_b} - {rdata_a[VAL_W-1], rdata_a};
  assign wext     = {1'b0, b2_w_r};
  assign prod_nxt = b2_d_r * wext;

  // floor of (slope * weight + half) / 2^weight_bits
  assign rnd  = (PROD_W + 1)'(b3_prod_r) + RND_HALF;
  assign step = rnd >>> WEIGHT_BITS;
  assign val  = b3_ok_r ? b3_low_r + step[VAL_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
    end else begin
      b1_v_r <= pop && !head.is_write;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b1_ok_r   <= head.sel_ok;
    b1_stat_r <= head.status;
    b1_w_r    <= head.weight;

    b2_ok_r   <= b1_ok_r;
    b2_stat_r <= b1_stat_r;
    b2_w_r    <= b1_w_r;
    b2_low_r  <= rdata_a;
    b2_d_r    <= d_nxt;

    b3_ok_r   <= b2_ok_r;
    b3_stat_r <= b2_stat_r;
    b3_low_r  <= b2_low_r;
    b3_prod_r <= prod_nxt;
  end

  assign ob_push    = b3_v_r;
  assign ob_pop     = out_valid && out_ready;
  assign out_valid  = ob_count_r != '0;
  assign out_value  = ob_val_r[ob_rptr_r];
  assign out_status = ob_stat_r[ob_rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wptr_r  <= '0;
      ob_rptr_r  <= '0;
      ob_count_r <= '0;
    end else begin
      if (ob_push) begin
        ob_wptr_r <= ob_wptr_r + OPTR_W'(1);
      end
      if (ob_pop) begin
        ob_rptr_r <= ob_rptr_r + OPTR_W'(1);
      end
      ob_count_r <= ob_count_r + OCNT_W'(ob_push) - OCNT_W'(ob_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_val_r[ob_wptr_r]  <= val;
      ob_stat_r[ob_wptr_r] <= b3_stat_r;
    end
  end

endmodule

// ===== rtl/uniform_lut_linear_interp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_lut_linear_interp_unit
// property tables on a uniform pressure grid with linear interpolation
// ----------------------------------------------------------------------------
// usage
//   in_*  : stream of items; in_tuser[0] = 1 writes one table entry, 0 asks
//           for the interpolated value at a pressure. writes give no result
//   out_* : one result item per query, in order: value and clip status
//   cfg_* : apb registers pressure_min (0x00), step_inverse (0x08) and
//           point_count (0x10); write them only while the block is idle
// timing
//   one item per clock while in_tready is high. a query reaches out_*
//   through three front stages (difference, 32x32 and 16x32 partial
//   products, position add and classify), the queue, then one ram read of
//   both neighbors and two stages of slope and weighting
// reset
//   pipeline and queues empty, registers at their defaults; table contents
//   are undefined until written
// stall
//   results wait in an 8-entry buffer; when it fills the back stops
//   draining the queue, and in_tready drops once the queue cannot hold
//   the items already in the front pipeline
// ----------------------------------------------------------------------------
module uniform_lut_linear_interp_unit
  import ulli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [47:0] pressure, [61:48] entry_index, [93:62] entry_value, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] action, [2:1] property_select
  input  logic [IN_USER_W-1:0]  in_tuser,
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] property_value
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] clip_status
  output logic [OUT_USER_W-1:0] out_tuser,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t              cfg_r;
  logic              cfg_wr;
  logic [REG_W-1:0]  cfg_sel;

  logic              q_push;
  qent_t             q_data;
  logic              q_pop;
  qent_t             q_head;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;

  // ---------------- configuration registers ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_paddr[CFG_AW-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressure_min <= '0;
      cfg_r.step_inverse <= STEP_W'(65536);
      cfg_r.point_count  <= PCNT_W'(16384);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PRESSURE_MIN: cfg_r.pressure_min <= cfg_pwdata[PRESS_W-1:0];
        REG_STEP_INVERSE: cfg_r.step_inverse <= cfg_pwdata[STEP_W-1:0];
        REG_POINT_COUNT:  cfg_r.point_count  <= cfg_pwdata[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, addresses beyond the list read zero
  always_comb begin
    unique case (cfg_sel)
      REG_PRESSURE_MIN: cfg_prdata = CFG_DW'(cfg_r.pressure_min);
      REG_STEP_INVERSE: cfg_prdata = CFG_DW'(cfg_r.step_inverse);
      REG_POINT_COUNT:  cfg_prdata = CFG_DW'(cfg_r.point_count);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------- front: position and classification ----------------
  ulli_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_action   (in_tuser[0]),
    .in_sel      (in_tuser[2:1]),
    .in_pressure (in_tdata[47:0]),
    .in_eidx     (in_tdata[61:48]),
    .in_evalue   (in_tdata[93:62]),
    .q_count     (q_count),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  // ---------------- queue between the halves ----------------
  ulli_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  // ---------------- back: table access and interpolation ----------------
  ulli_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_tdata),
    .out_status (out_tuser)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the uniform grid interpolation unit
// ----------------------------------------------------------------------------
// items are queued by the stimulus process and played into in_* by a clocked
// driver. each accepted write to a valid table updates its shadow, and each
// accepted query adds one predicted result. a clocked monitor on out_* checks
// results in order. the run steps through several register settings that
// are written over apb while the unit is idle. before a query is queued,
// any table entry that it reads and that was never loaded is loaded first
// ----------------------------------------------------------------------------
module tb_top;
  import ulli_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 24;    // writes give no result
  localparam int RESULT_WAIT  = 5000;  // bound on the wait for outstanding results
  localparam int REPORT_MAX   = 10;

  // one input item, split into its fields
  typedef struct {
    logic              act;
    logic [SEL_W-1:0]  sel;
    logic [PRESS_W-1:0] pressure;
    logic [EIDX_W-1:0] entry_idx;
    logic [VAL_W-1:0]  entry_val;
  } lut_item_t;

  // one result item
  typedef struct {
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] clip;
  } lut_result_t;

  // where a pressure falls on the grid
  typedef struct {
    logic [STAT_W-1:0]      clip;
    bit                     interp;
    int unsigned            lo_idx;
    logic [WEIGHT_BITS-1:0] weight;
  } grid_pos_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // pressure, entry_index, entry_value
  logic [IN_USER_W-1:0]  in_tuser = '0;    // action, property_select
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // property_value
  logic [OUT_USER_W-1:0] out_tuser;        // clip_status
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  uniform_lut_linear_interp_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the registers, starting at their reset values
  logic signed [PRESS_W-1:0] pmin_sh = '0;
  logic [STEP_W-1:0]         step_sh = 32'd65536;
  logic [PCNT_W-1:0]         pcnt_sh = 15'd16384;

  // shadow of the tables as the unit sees them, in acceptance order
  logic signed [VAL_W-1:0] lut_model [0:DEPTH-1];
  // entries loaded so far, in queue order; keeps queries off unloaded entries
  bit lut_filled [0:DEPTH-1];

  lut_item_t   item_queue[$];
  lut_result_t expected_lookups[$];
  int unsigned items_pushed = 0;
  int unsigned error_count = 0;

  // driver and monitor state
  lut_item_t   drive_item;
  int unsigned in_gap_left = 0;
  int unsigned out_stall_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // point_count outside 2..GRID_POINTS is clamped
  function automatic int unsigned point_span();
    if (pcnt_sh < 2) return 2;
    if (pcnt_sh > GRID_POINTS) return GRID_POINTS;
    return int'(pcnt_sh);
  endfunction

  // grid position is (pressure - pressure_min) * step_inverse with 32 fraction bits
  function automatic grid_pos_t grid_locate(logic [PRESS_W-1:0] p);
    logic signed [63:0] diff;
    logic signed [63:0] base;
    logic [95:0]        pos;
    logic [63:0]        whole;
    int unsigned        last;
    grid_pos_t          g;
    last = point_span() - 1;
    base = pmin_sh;
    diff = $signed(p);
    diff = diff - base;
    g.interp = 1'b0;
    g.weight = '0;
    g.lo_idx = 0;
    if (diff < 0) begin
      g.clip = CLIP_BELOW;
    end else begin
      pos = {32'd0, diff} * {64'd0, step_sh};
      whole = pos[95:32];
      g.lo_idx = last;
      if (whole > 64'(last) || (whole == 64'(last) && pos[31:0] != 32'd0)) begin
        g.clip = CLIP_ABOVE;
      end else if (whole == 64'(last)) begin
        // exactly on the last point
        g.clip = CLIP_NONE;
      end else begin
        g.clip = CLIP_NONE;
        g.interp = 1'b1;
        g.lo_idx = int'(whole);
        g.weight = pos[31:32-WEIGHT_BITS];
      end
    end
    return g;
  endfunction

  // low + round(weight * (high - low)), rounding half up
  function automatic lut_result_t interp_lookup(logic [SEL_W-1:0] sel, logic [PRESS_W-1:0] p);
    grid_pos_t          g;
    lut_result_t        r;
    logic signed [63:0] low;
    logic signed [63:0] high;
    logic signed [63:0] slope;
    logic signed [63:0] sum;
    int unsigned        base;
    g = grid_locate(p);
    r.clip = g.clip;
    base = int'(sel) * GRID_POINTS + g.lo_idx;
    if (sel >= PROPERTY_COUNT) begin
      r.value = '0;
    end else if (!g.interp) begin
      r.value = lut_model[base];
    end else begin
      low = lut_model[base];
      high = lut_model[base + 1];
      slope = (high - low) * $signed({48'd0, g.weight}) + (64'sd1 <<< (WEIGHT_BITS - 1));
      sum = low + (slope >>> WEIGHT_BITS);
      r.value = sum[VAL_W-1:0];
    end
    return r;
  endfunction

  // effect of one accepted item
  function automatic void apply_item(lut_item_t it);
    if (it.act == ACT_WRITE) begin
      if (it.sel < PROPERTY_COUNT)
        lut_model[int'(it.sel) * GRID_POINTS + int'(it.entry_idx)] = it.entry_val;
    end else begin
      expected_lookups.push_back(interp_lookup(it.sel, it.pressure));
    end
  endfunction

  function automatic void note_error(string msg);
    if (error_count < REPORT_MAX) $display("%s", msg);
    error_count++;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: next item goes out once the current one is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) apply_item(drive_item);
      // occasional stretches without gaps
      if ($urandom_range(0, 199) == 0) in_calm = !in_calm;
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_tvalid <= 1'b0;
      end else if (item_queue.size() > 0) begin
        drive_item = item_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {2'b00, drive_item.entry_val, drive_item.entry_idx, drive_item.pressure};
        in_tuser <= {drive_item.sel, drive_item.act};
        in_gap_left = in_calm ? 0 : draw_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor with random back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lut_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_lookups.size() == 0) begin
          note_error($sformatf("unexpected result value=%h clip=%0d",
                               out_tdata, out_tuser));
        end else begin
          want = expected_lookups.pop_front();
          if (out_tdata !== want.value || out_tuser !== want.clip)
            note_error($sformatf("result mismatch: expected value=%h clip=%0d, got value=%h clip=%0d",
                                 want.value, want.clip, out_tdata, out_tuser));
        end
      end
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall_left = out_calm ? 0 : draw_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // apb write: setup, access, done once pready is seen with penable
  task automatic cfg_write(logic [REG_W-1:0] reg_sel, logic [CFG_DW-1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (reg_sel)
      REG_PRESSURE_MIN: pmin_sh = value[PRESS_W-1:0];
      REG_STEP_INVERSE: step_sh = value[STEP_W-1:0];
      REG_POINT_COUNT:  pcnt_sh = value[PCNT_W-1:0];
      default: ;
    endcase
  endtask

  // all items taken, results drained (bounded), then let writes settle
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    do @(negedge clk); while (item_queue.size() != 0 || in_tvalid);
    while (expected_lookups.size() != 0 && waited < RESULT_WAIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] table_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_write(logic [SEL_W-1:0] sel, logic [EIDX_W-1:0] idx, logic [VAL_W-1:0] value);
    lut_item_t it;
    it.act = ACT_WRITE;
    it.sel = sel;
    it.pressure = 48'({$urandom, $urandom});
    it.entry_idx = idx;
    it.entry_val = value;
    if (sel < PROPERTY_COUNT) lut_filled[int'(sel) * GRID_POINTS + int'(idx)] = 1'b1;
    item_queue.push_back(it);
    items_pushed++;
  endtask

  task automatic fill_if_empty(logic [SEL_W-1:0] sel, int unsigned idx);
    if (!lut_filled[int'(sel) * GRID_POINTS + idx])
      push_write(sel, EIDX_W'(idx), table_value());
  endtask

  // a query, preceded by loads of any entry it reads that is still empty
  task automatic push_query(logic [SEL_W-1:0] sel, logic [PRESS_W-1:0] p);
    grid_pos_t g;
    lut_item_t it;
    g = grid_locate(p);
    if (sel < PROPERTY_COUNT) begin
      fill_if_empty(sel, g.lo_idx);
      if (g.interp) fill_if_empty(sel, g.lo_idx + 1);
    end
    it.act = ACT_QUERY;
    it.sel = sel;
    it.pressure = p;
    it.entry_idx = EIDX_W'($urandom);
    it.entry_val = $urandom;
    item_queue.push_back(it);
    items_pushed++;
  endtask

  // pressure landing near a chosen grid position, random if out of range
  function automatic logic [PRESS_W-1:0] aim_pressure(int unsigned idx, logic [31:0] frac);
    logic [95:0]        target;
    logic [95:0]        dq;
    logic signed [63:0] p64;
    target = {32'd0, 32'(idx), frac};
    if (step_sh == '0) dq = 96'($urandom_range(0, 4096));
    else dq = target / {64'd0, step_sh};
    p64 = pmin_sh;
    p64 = p64 + $signed({1'b0, dq[62:0]});
    if (dq[95:63] != '0 || p64[63:PRESS_W-1] != {(65-PRESS_W){p64[PRESS_W-1]}})
      return PRESS_W'({$urandom, $urandom});
    return p64[PRESS_W-1:0];
  endfunction

  task automatic push_random_item();
    int unsigned      kind;
    int unsigned      last;
    int unsigned      idx;
    logic [SEL_W-1:0] sel;
    logic signed [63:0] below;
    kind = $urandom_range(0, 99);
    last = point_span() - 1;
    sel = ($urandom_range(0, 99) < 8) ? SEL_W'(3) : SEL_W'($urandom_range(0, PROPERTY_COUNT - 1));
    if (kind < 20) begin
      // table load, any select, any index
      sel = SEL_W'($urandom_range(0, 3));
      idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, GRID_POINTS - 1)
                                        : $urandom_range(0, last);
      push_write(sel, EIDX_W'(idx), table_value());
    end else if (kind < 35) begin
      push_query(sel, PRESS_W'({$urandom, $urandom}));
    end else if (kind < 50) begin
      // around the grid ends
      case ($urandom_range(0, 5))
        0: begin
          below = pmin_sh;
          below = below - 1;
          push_query(sel, (below[63:PRESS_W-1] == {(65-PRESS_W){below[PRESS_W-1]}})
                          ? below[PRESS_W-1:0] : pmin_sh);
        end
        1: push_query(sel, pmin_sh);
        2: push_query(sel, aim_pressure(last, 32'd0));
        3: push_query(sel, aim_pressure(last, 32'hFFFF_FFFF));
        4: push_query(sel, aim_pressure(last - 1, 32'hFFFF_FFFF));
        default: push_query(sel, aim_pressure(last + 1, $urandom));
      endcase
    end else begin
      // inside the grid, often near the start to reuse loaded entries
      idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, (last < 15) ? last : 15)
                                        : $urandom_range(0, last);
      push_query(sel, aim_pressure(idx, $urandom));
    end
  endtask

  task automatic run_phase(logic [PRESS_W-1:0] pmin, logic [STEP_W-1:0] step,
                           logic [PCNT_W-1:0] pcnt, int unsigned n);
    int unsigned start;
    wait_idle();
    // bits above each register's width are don't-care
    cfg_write(REG_PRESSURE_MIN, {16'($urandom), pmin});
    cfg_write(REG_STEP_INVERSE, {32'($urandom), step});
    cfg_write(REG_POINT_COUNT, {49'({$urandom, $urandom}), pcnt});
    @(negedge clk);
    start = items_pushed;
    while (items_pushed - start < n) push_random_item();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned k;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed items on reset settings: one point per pascal, full tables
    push_write(0, 0, 32'h7FFF_FFFF);
    push_write(0, 1, 32'h8000_0000);
    push_write(0, 2, 32'h0000_0000);
    push_write(1, 0, 32'hFFFF_FFFB);
    push_write(1, 1, 32'd100);
    push_write(2, 16383, 32'h1234_5678);
    push_write(2, 16382, 32'h8000_0000);
    push_write(3, 7, 32'h0000_0001);               // select out of range, dropped
    push_query(0, 48'h0000_0000_0000);             // on point 0
    push_query(0, 48'h0000_0000_FFFF);             // largest weight, steepest drop
    push_query(0, 48'h0000_0001_8000);             // half way
    push_query(1, 48'h0000_0000_8000);             // half way
    push_query(1, 48'h0000_0000_0001);             // smallest weight
    push_query(0, 48'hFFFF_FFFF_FFFF);             // just below the grid
    push_query(1, 48'h8000_0000_0000);             // most negative pressure
    push_query(2, 48'h0000_3FFF_0000);             // exactly on the last point
    push_query(2, 48'h0000_3FFF_0001);             // just above the grid
    push_query(2, 48'h0000_3FFE_FFFF);             // last interval, full weight
    push_query(2, 48'h7FFF_FFFF_FFFF);             // most positive pressure
    push_query(3, 48'h0000_0001_0000);             // select out of range, inside
    push_query(3, 48'hFFFF_FFFF_0000);             // select out of range, below
    push_query(3, 48'h0000_7FFF_0000);             // select out of range, above

    run_phase(-48'sd6553600, 32'd262144, 15'd64, 220);
    run_phase(48'h8000_0000_0000, 32'hFFFF_FFFF, 15'd2, 200);
    run_phase(48'h7FFF_FFFF_FFFF, 32'd1, 15'd16384, 120);
    run_phase(48'h0, 32'd0, 15'd0, 180);           // zero step, count below range
    run_phase(PRESS_W'({$urandom, $urandom}), $urandom, 15'd32767, 220);
    run_phase(48'h0000_3039_0000, 32'd8192, 15'd1, 200);
    run_phase(-48'sd65536, 32'd65536, 15'd16384, 250);
    for (k = 0; k < 3; k++)
      run_phase(PRESS_W'($signed(32'($urandom))), $urandom_range(1, 32'h0040_0000),
                PCNT_W'($urandom_range(2, 300)), 190);

    wait_idle();
    if (expected_lookups.size() != 0)
      note_error($sformatf("%0d expected results never arrived", expected_lookups.size()));
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ulli_pkg.sv
rtl/ulli_ram.sv
rtl/ulli_front.sv
rtl/ulli_queue.sv
rtl/ulli_back.sv
rtl/uniform_lut_linear_interp_unit.sv
sim/tb_top.sv
